>>> rtl/nll_pkg.sv
// nll_pkg: shared types, codes and character constants of the numeric literal lexer
// used by nll_step.sv and numeric_literal_lexer.sv; no dependencies
`timescale 1ns / 1ps

package nll_pkg;

  // error codes carried in the result item
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_INT   = 2'd1;
  localparam logic [1:0] ERR_FLOAT = 2'd2;

  // token kinds
  localparam logic KIND_INT   = 1'b0;
  localparam logic KIND_FLOAT = 1'b1;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UE    = 8'h45;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_X     = 8'h78;

  // literal scanning state
  typedef struct packed {
    logic        in_literal;
    logic        discarding;
    logic        hex_mode;
    logic        dot_seen;
    logic        exponent_seen;
    logic        sign_seen;
    logic [1:0]  char_position;
    logic        prev_was_zero;
    logic        prev_was_exp;
    logic [63:0] accumulator;
  } lex_state_t;

  localparam lex_state_t LEX_CLEAR = '0;

  // one result item
  typedef struct packed {
    logic        end_of_text;
    logic        token_valid;
    logic        token_kind;
    logic [1:0]  error_code;
    logic [63:0] int_value;
  } lex_result_t;

endpackage

>>> rtl/nll_if.sv
// nll_if: valid/ready channel interfaces for characters in and lexer results out
// no dependencies
`timescale 1ns / 1ps

interface nll_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface nll_result_if;
  logic               valid;
  logic               ready;
  logic               end_of_text;
  logic               token_valid;
  logic               token_kind;
  logic [1:0]         error_code;
  logic signed [63:0] int_value;

  modport source (output valid, output end_of_text, output token_valid,
                  output token_kind, output error_code, output int_value,
                  input ready);
  modport sink (input valid, input end_of_text, input token_valid,
                input token_kind, input error_code, input int_value,
                output ready);
endinterface

>>> rtl/nll_step.sv
// nll_step: combinational next state and result for one character item
// depends on nll_pkg (state and result types, codes, character constants)
`timescale 1ns / 1ps

module nll_step
  import nll_pkg::*;
(
  input  lex_state_t  state_i,
  input  logic [7:0]  char_i,
  output lex_state_t  state_o,
  output logic        emit_o,
  output lex_result_t result_o
);

  logic        is_dec;
  logic        is_close;
  logic        is_hex_letter;
  logic        is_e;
  logic [3:0]  digit;
  logic [3:0]  letter_val;
  logic [63:0] acc_x10;
  logic [63:0] acc_x16_dig;
  logic [63:0] acc_x16_let;
  logic [63:0] acc_x16_e;
  logic        fail;
  logic [1:0]  fail_code;
  lex_state_t  upd;

  // character classes
  assign is_dec   = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
  assign is_close = (char_i == CH_NUL) || (char_i == CH_SPACE) ||
                    (char_i == CH_TAB) || (char_i == CH_NL);
  assign is_e     = (char_i == CH_LE) || (char_i == CH_UE);
  assign is_hex_letter = ((char_i >= CH_LA) && (char_i <= CH_LF) && (char_i != CH_LE)) ||
                         ((char_i >= CH_UA) && (char_i <= CH_UF) && (char_i != CH_UE));
  assign digit      = char_i[3:0];
  // letters a..f / A..F have low nibble 1..6, value 10..15
  assign letter_val = char_i[3:0] + 4'd9;

  // accumulate by shift and add
  assign acc_x10     = {state_i.accumulator[60:0], 3'b000} +
                       {state_i.accumulator[62:0], 1'b0} + {60'd0, digit};
  assign acc_x16_dig = {state_i.accumulator[59:0], digit};
  assign acc_x16_let = {state_i.accumulator[59:0], letter_val};
  assign acc_x16_e   = {state_i.accumulator[59:0], 4'he};

  // update of a literal by a byte that does not close it
  always_comb begin
    upd       = state_i;
    fail      = 1'b0;
    fail_code = ERR_OK;
    if (is_dec) begin
      upd.accumulator = state_i.hex_mode ? acc_x16_dig : acc_x10;
    end else if (char_i == CH_X) begin
      if (state_i.char_position != 2'd1 || !state_i.prev_was_zero || state_i.hex_mode) begin
        fail      = 1'b1;
        fail_code = ERR_INT;
      end else begin
        upd.hex_mode = 1'b1;
      end
    end else if (is_hex_letter) begin
      if (!state_i.hex_mode) begin
        fail      = 1'b1;
        fail_code = ERR_INT;
      end else begin
        upd.accumulator = acc_x16_let;
      end
    end else if (is_e) begin
      if (state_i.hex_mode) begin
        upd.accumulator = acc_x16_e;
      end else if (state_i.exponent_seen) begin
        fail      = 1'b1;
        fail_code = ERR_FLOAT;
      end else begin
        upd.exponent_seen = 1'b1;
      end
    end else if (char_i == CH_DOT) begin
      if (state_i.hex_mode) begin
        fail      = 1'b1;
        fail_code = ERR_INT;
      end else if (state_i.dot_seen) begin
        fail      = 1'b1;
        fail_code = ERR_FLOAT;
      end else begin
        upd.dot_seen = 1'b1;
      end
    end else if (char_i == CH_PLUS || char_i == CH_MINUS) begin
      if (state_i.char_position < 2'd2 || !state_i.exponent_seen ||
          !state_i.prev_was_exp || state_i.sign_seen) begin
        fail      = 1'b1;
        fail_code = ERR_FLOAT;
      end else begin
        upd.sign_seen = 1'b1;
      end
    end else begin
      fail      = 1'b1;
      fail_code = ERR_INT;
    end
    upd.prev_was_zero = (char_i == CH_ZERO);
    upd.prev_was_exp  = is_e;
    if (state_i.char_position < 2'd2) begin
      upd.char_position = state_i.char_position + 2'd1;
    end
  end

  // top-level decision: idle/discarding, close, or inside a literal
  always_comb begin
    state_o  = state_i;
    emit_o   = 1'b0;
    result_o = '0;
    if (state_i.discarding || !state_i.in_literal) begin
      if (char_i == CH_NUL) begin
        state_o              = LEX_CLEAR;
        emit_o               = 1'b1;
        result_o.end_of_text = 1'b1;
      end else if (!state_i.discarding && is_dec) begin
        state_o               = LEX_CLEAR;
        state_o.in_literal    = 1'b1;
        state_o.char_position = 2'd1;
        state_o.prev_was_zero = (char_i == CH_ZERO);
        state_o.accumulator   = {60'd0, digit};
      end
    end else if (is_close) begin
      state_o              = LEX_CLEAR;
      emit_o               = 1'b1;
      result_o.end_of_text = (char_i == CH_NUL);
      result_o.token_valid = 1'b1;
      if (state_i.exponent_seen || state_i.dot_seen) begin
        result_o.token_kind = KIND_FLOAT;
      end else begin
        result_o.token_kind = KIND_INT;
        result_o.int_value  = state_i.accumulator;
      end
    end else if (fail) begin
      state_o             = LEX_CLEAR;
      state_o.discarding  = 1'b1;
      emit_o              = 1'b1;
      result_o.error_code = fail_code;
    end else begin
      state_o = upd;
    end
  end

endmodule

>>> rtl/numeric_literal_lexer.sv
// numeric_literal_lexer: top level with input register, step logic and result register
// depends on nll_pkg, nll_if (channel interfaces) and nll_step
`timescale 1ns / 1ps

// Usage:
//   in_i carries one text byte per item (char_code); 0 ends the text.
//   out_o carries one result item when a literal closes, when a bad byte
//   makes the literal invalid, or when the terminating NUL arrives.
//   Bytes that cause no result are consumed silently.
// Timing:
//   an accepted byte is held in the input register; the step logic
//   then updates the scan state and, if a result follows, loads the result
//   register as the byte moves on, so out_o.valid is driven from the
//   result register.
//   One byte is taken per cycle unless out_o stalls; the loop that sets this is
//   the scan state register feeding back through a shift-and-add accumulate.
// Reset:
//   rst_ni clears the scan state and both valid flags; the block then waits
//   for the first byte of a new text.
// Stall:
//   while out_o.ready is low with a result waiting, the input register holds
//   its byte and in_i.ready drops only once that register is occupied.

module numeric_literal_lexer
  import nll_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  nll_char_if.sink       in_i,
  nll_result_if.source   out_o
);

  logic        in_valid_q;
  logic [7:0]  in_char_q;
  lex_state_t  state_q;
  lex_state_t  state_d;
  logic        emit;
  lex_result_t step_res;
  logic        out_valid_q;
  lex_result_t out_res_q;
  logic        advance;

  // the stored byte moves on when the result register is free or draining
  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_char_q <= in_i.char_code;
    end
  end

  // per-item scan logic
  nll_step u_step (
    .state_i  (state_q),
    .char_i   (in_char_q),
    .state_o  (state_d),
    .emit_o   (emit),
    .result_o (step_res)
  );

  // scan state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LEX_CLEAR;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_res_q <= step_res;
    end
  end

  // output channel
  assign out_o.valid       = out_valid_q;
  assign out_o.end_of_text = out_res_q.end_of_text;
  assign out_o.token_valid = out_res_q.token_valid;
  assign out_o.token_kind  = out_res_q.token_kind;
  assign out_o.error_code  = out_res_q.error_code;
  assign out_o.int_value   = $signed(out_res_q.int_value);

endmodule
